### src/assert_macros.svh
// Assertion macros shared by the playhead RTL modules.
// Depends on nothing; each user passes its own clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("playhead assertion failed");

// Next-cycle implication checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("playhead assertion failed");

`endif

### src/arp_pkg.sv
// Shared types, constants and the speed-to-rate table of the playhead.
// Depends on nothing; every playhead module imports it.
`default_nettype none

package arp_pkg;

  // Sizes of the range table and of the fixed-point words.
  localparam int NUM_RANGES = 16;
  localparam int FRAME_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int POS_W      = FRAME_BITS + FRAC_BITS;
  localparam int SEG_W      = $clog2(NUM_RANGES);
  localparam int CNT_W      = $clog2(NUM_RANGES + 1);
  localparam int RMAG_W     = 17;
  localparam int RATE_W     = RMAG_W + 1;
  localparam int STEP_W     = 17;
  localparam int PROD_W     = RMAG_W + STEP_W;
  localparam int SUM_W      = POS_W + 2;
  localparam int SPEED_W    = 8;
  localparam int LOOP_W     = 16;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  // Command codes.
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // End-of-table behavior codes.
  localparam logic [1:0] MODE_STOP    = 2'd0;
  localparam logic [1:0] MODE_LOOP    = 2'd1;
  localparam logic [1:0] MODE_REBOUND = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_CYCLE_MODE   = 2'd0;
  localparam logic [1:0] REG_RANGE_COUNT  = 2'd1;
  localparam logic [1:0] REG_ADVANCE_STEP = 2'd2;

  localparam logic [CNT_W-1:0]  RANGE_COUNT_RST  = CNT_W'(1);
  localparam logic [STEP_W-1:0] ADVANCE_STEP_RST = STEP_W'(32768);

  typedef struct packed {
    logic [1:0]                cmd;
    logic [3:0]                range_index;
    logic signed [15:0]        start_frame;
    logic signed [15:0]        end_frame;
    logic [SPEED_W-1:0]        speed;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0]        frame;
    logic [15:0]               position_fraction;
    logic signed [15:0]        previous_frame;
    logic [3:0]                segment;
    logic [15:0]               loop_count;
    logic                      stopped;
  } out_item_t;

  typedef struct packed {
    logic [1:0]                cycle_mode;
    logic [CNT_W-1:0]          range_count;
    logic [STEP_W-1:0]         advance_step;
  } cfg_t;

  // Which range-table entry the datapath reads.
  typedef enum logic [1:0] {
    RD_CUR,
    RD_NEIGHBOR,
    RD_FIRST
  } rd_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    cap_in;
    logic    mem_wr;
    logic    mem_rd;
    rd_sel_t rd_sel;
    logic    mult_en;
    logic    add_en;
    logic    apply_tick;
    logic    apply_start;
    logic    out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] cmd;
    logic       out_busy;
  } dp_status_t;

  // Rate for every speed: 65536 / speed truncated, speed zero gives 65536.
  typedef logic [(1 << SPEED_W)-1:0][RMAG_W-1:0] rate_lut_t;

  // Built at elaboration by shift-and-subtract division.
  function automatic rate_lut_t build_rate_lut();
    rate_lut_t          lut;
    logic [RMAG_W-1:0]  dvd;
    logic [RMAG_W-1:0]  quo;
    logic [RMAG_W:0]    rem;
    dvd = RMAG_W'(1 << FRAC_BITS);
    for (int s = 0; s < (1 << SPEED_W); s++) begin
      if (s == 0) begin
        lut[s] = dvd;
      end else begin
        rem = '0;
        quo = '0;
        for (int b = RMAG_W - 1; b >= 0; b--) begin
          rem = {rem[RMAG_W-1:0], dvd[b]};
          if (rem >= (RMAG_W+1)'(s)) begin
            rem    = rem - (RMAG_W+1)'(s);
            quo[b] = 1'b1;
          end
        end
        lut[s] = quo;
      end
    end
    return lut;
  endfunction

  localparam rate_lut_t RATE_LUT = build_rate_lut();

endpackage

`default_nettype wire

### src/arp_regs.sv
// Configuration register file on the APB-style port of the playhead.
// Depends on arp_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module arp_regs
  import arp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cycle_mode   <= MODE_STOP;
      cfg.range_count  <= RANGE_COUNT_RST;
      cfg.advance_step <= ADVANCE_STEP_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CYCLE_MODE:   cfg.cycle_mode   <= pwdata[1:0];
        REG_RANGE_COUNT:  cfg.range_count  <= pwdata[CNT_W-1:0];
        REG_ADVANCE_STEP: cfg.advance_step <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (reg_idx)
      REG_CYCLE_MODE:   prdata = DATA_W'(cfg.cycle_mode);
      REG_RANGE_COUNT:  prdata = DATA_W'(cfg.range_count);
      REG_ADVANCE_STEP: prdata = DATA_W'(cfg.advance_step);
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### src/arp_ctrl.sv
// Controller state machine of the playhead: sequences load, start and tick.
// Depends on arp_pkg for the command and status structs.
`default_nettype none
`include "assert_macros.svh"

module arp_ctrl
  import arp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_START,
    S_ADD,
    S_APPLY,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_fire;
  logic   finish_ok;

  // A new transaction is taken when idle, or in the cycle the result leaves.
  assign finish_ok = (state == S_FINISH) && !status.out_busy;
  assign in_stall  = !((state == S_IDLE) || finish_ok);
  assign in_fire   = in_valid && !in_stall;

  // Next state and datapath commands.
  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.rd_sel      = RD_CUR;
    cmd.cap_in      = in_fire;
    unique case (state)
      S_IDLE: begin
        if (in_fire) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (status.cmd)
          CMD_LOAD: begin
            cmd.mem_wr = 1'b1;
            state_next = S_FINISH;
          end
          CMD_START: begin
            cmd.mem_rd = 1'b1;
            cmd.rd_sel = RD_FIRST;
            state_next = S_START;
          end
          CMD_TICK: begin
            cmd.mem_rd  = 1'b1;
            cmd.rd_sel  = RD_CUR;
            cmd.mult_en = 1'b1;
            state_next  = S_ADD;
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_START: begin
        cmd.apply_start = 1'b1;
        state_next      = S_FINISH;
      end
      S_ADD: begin
        cmd.add_en = 1'b1;
        cmd.mem_rd = 1'b1;
        cmd.rd_sel = RD_NEIGHBOR;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply_tick = 1'b1;
        state_next     = S_FINISH;
      end
      S_FINISH: begin
        if (finish_ok) begin
          cmd.out_load = 1'b1;
          state_next   = in_fire ? S_DISPATCH : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Every accepted transaction is decoded in the following cycle.
  `ASSERT_NEXT(a_fire_dispatch, clk, rst, in_fire, state == S_DISPATCH)
  // A result is never loaded over one that the receiver still holds off.
  `ASSERT_IMPL(a_no_overwrite, clk, rst, cmd.out_load, !status.out_busy)

endmodule

`default_nettype wire

### src/arp_dp.sv
// Datapath of the playhead: range table, position, rate, step multiply,
// boundary test and the output register. Depends on arp_pkg.
`default_nettype none
`include "assert_macros.svh"

module arp_dp
  import arp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_data,
  input  wire cfg_t       cfg,
  input  wire ctrl_cmd_t  cmd,
  output dp_status_t      status
);

  typedef struct packed {
    logic signed [15:0]  start_frame;
    logic signed [15:0]  end_frame;
    logic [RMAG_W-1:0]   rate_mag;
  } range_entry_t;

  range_entry_t              mem [NUM_RANGES];
  range_entry_t              rd_q;
  in_item_t                  in_reg;

  logic signed [POS_W-1:0]   pos;
  logic signed [RATE_W-1:0]  rate;
  logic [SEG_W-1:0]          seg;
  logic [LOOP_W-1:0]         loops;
  logic [FRAME_BITS-1:0]     last_frame;
  logic [PROD_W-1:0]         prod;
  logic signed [POS_W-1:0]   next_pos;
  logic                      leave;

  logic [CNT_W-1:0]          used;
  logic                      rate_pos;
  logic                      go_fwd;
  logic                      go_back;
  logic [SEG_W-1:0]          neighbor;
  logic [SEG_W-1:0]          rd_addr;
  logic [RMAG_W-1:0]         rate_mag;
  logic [POS_W-1:0]          pos_mag;
  logic signed [SUM_W-1:0]   pos_ext;
  logic signed [SUM_W-1:0]   delta;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   lo_bound;
  logic signed [SUM_W-1:0]   hi_bound;
  logic                      outside;
  logic                      ovf;
  logic signed [POS_W-1:0]   sat;
  logic signed [SUM_W-1:0]   sat_ext;
  logic signed [RATE_W-1:0]  entry_rate;

  // Whole frame of a position, truncated toward zero.
  function automatic logic [FRAME_BITS-1:0] whole_frame(input logic [POS_W-1:0] p);
    logic [POS_W-1:0]      m;
    logic [FRAME_BITS-1:0] w;
    m = p[POS_W-1] ? (~p + POS_W'(1)) : p;
    w = m[POS_W-1:FRAC_BITS];
    return p[POS_W-1] ? (~w + FRAME_BITS'(1)) : w;
  endfunction

  assign status.cmd      = in_reg.cmd;
  assign status.out_busy = out_valid && out_stall;

  // Ranges in use, clamped to one through the table depth.
  always_comb begin
    if (cfg.range_count == '0) begin
      used = CNT_W'(1);
    end else if (cfg.range_count > CNT_W'(NUM_RANGES)) begin
      used = CNT_W'(NUM_RANGES);
    end else begin
      used = cfg.range_count;
    end
  end

  // Neighbor entry chosen by the direction of travel; entry 0 otherwise.
  assign rate_pos = !rate[RATE_W-1] && (rate != '0);
  assign go_fwd   = rate_pos && (({1'b0, seg} + CNT_W'(1)) < used);
  assign go_back  = rate[RATE_W-1] && (seg != '0);

  always_comb begin
    if (go_fwd) begin
      neighbor = seg + SEG_W'(1);
    end else if (go_back) begin
      neighbor = seg - SEG_W'(1);
    end else begin
      neighbor = '0;
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_CUR:      rd_addr = seg;
      RD_NEIGHBOR: rd_addr = neighbor;
      RD_FIRST:    rd_addr = '0;
      default:     rd_addr = seg;
    endcase
  end

  // Input capture and range table with a registered read port.
  always_ff @(posedge clk) begin
    if (cmd.cap_in) in_reg <= in_data;
    if (cmd.mem_wr) begin
      mem[in_reg.range_index] <= '{start_frame: in_reg.start_frame,
                                   end_frame:   in_reg.end_frame,
                                   rate_mag:    RATE_LUT[in_reg.speed]};
    end
    if (cmd.mem_rd) rd_q <= mem[rd_addr];
  end

  // Step magnitude, next position with saturation, and the range test.
  assign rate_mag = rate[RATE_W-1] ? RMAG_W'(-rate) : rate[RMAG_W-1:0];
  assign pos_ext  = {{(SUM_W-POS_W){pos[POS_W-1]}}, pos};
  always_comb begin
    delta = {{(SUM_W-(PROD_W-FRAC_BITS)){1'b0}}, prod[PROD_W-1:FRAC_BITS]};
    if (rate[RATE_W-1]) delta = -delta;
  end
  assign sum      = pos_ext + delta;
  assign lo_bound = {{(SUM_W-POS_W){rd_q.start_frame[15]}}, rd_q.start_frame,
                     {FRAC_BITS{1'b0}}};
  assign hi_bound = {{(SUM_W-POS_W){rd_q.end_frame[15]}}, rd_q.end_frame,
                     {FRAC_BITS{1'b0}}};
  assign ovf      = sum[SUM_W-1:POS_W-1] != {(SUM_W-POS_W+1){sum[POS_W-1]}};
  always_comb begin
    if (!ovf) begin
      sat = sum[POS_W-1:0];
    end else if (sum[SUM_W-1]) begin
      sat = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(POS_W-1){1'b1}}};
    end
  end

  // The range test sees the saturated position, so a range that starts at
  // the bottom of the frame scale holds a position pinned there.
  assign sat_ext  = {{(SUM_W-POS_W){sat[POS_W-1]}}, sat};
  assign outside  = (sat_ext < lo_bound) || (sat_ext > hi_bound);

  assign entry_rate = {1'b0, rd_q.rate_mag};
  assign pos_mag    = pos[POS_W-1] ? (~pos + POS_W'(1)) : pos;

  // Playhead state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      rate       <= '0;
      seg        <= '0;
      loops      <= '0;
      last_frame <= '0;
    end else begin
      if (cmd.mult_en) last_frame <= whole_frame(pos);
      if (cmd.apply_start) begin
        seg        <= '0;
        pos        <= {rd_q.start_frame, {FRAC_BITS{1'b0}}};
        last_frame <= '1;
        rate       <= entry_rate;
        loops      <= '0;
      end
      if (cmd.apply_tick) begin
        if (!leave) begin
          pos <= next_pos;
        end else if (go_fwd) begin
          seg  <= seg + SEG_W'(1);
          pos  <= {rd_q.start_frame, {FRAC_BITS{1'b0}}};
          rate <= entry_rate;
        end else if (go_back) begin
          seg  <= seg - SEG_W'(1);
          pos  <= {rd_q.end_frame, {FRAC_BITS{1'b0}}};
          rate <= -entry_rate;
        end else if (cfg.cycle_mode == MODE_LOOP) begin
          seg   <= '0;
          pos   <= {rd_q.start_frame, {FRAC_BITS{1'b0}}};
          rate  <= entry_rate;
          loops <= loops + LOOP_W'(1);
        end else if (cfg.cycle_mode == MODE_REBOUND) begin
          pos  <= next_pos;
          rate <= -rate;
          if (rate[RATE_W-1]) loops <= loops + LOOP_W'(1);
        end else begin
          rate <= '0;
        end
      end
    end
  end

  // Product and add registers; a stopped playhead keeps its position.
  always_ff @(posedge clk) begin
    if (cmd.mult_en) prod <= PROD_W'(rate_mag) * PROD_W'(cfg.advance_step);
    if (cmd.add_en) begin
      next_pos <= (rate == '0) ? pos : sat;
      leave    <= outside && (rate != '0);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.frame             <= whole_frame(pos);
      out_data.position_fraction <= pos_mag[FRAC_BITS-1:0];
      out_data.previous_frame    <= last_frame;
      out_data.segment           <= seg;
      out_data.loop_count        <= loops;
      out_data.stopped           <= (rate == '0);
    end
  end

  // The rate never leaves plus or minus one frame per unit step.
  `ASSERT_IMPL(a_rate_range, clk, rst, 1'b1, (rate <= 65536) && (rate >= -65536))
  // A loaded result reports the rate state it was taken from.
  `ASSERT_NEXT(a_stopped_flag, clk, rst, cmd.out_load, out_data.stopped == (rate == '0))

endmodule

`default_nettype wire

### src/anim_range_playhead.sv
// Playhead over a table of frame ranges.
// Channels: in_valid/in_stall/in_data carries commands (load, start, tick);
// out_valid/out_stall/out_data returns one result per command, showing
// the state after that command. A transaction moves at a rising edge with
// valid high and stall low. Configuration (cycle mode, range count, advance
// step) is written at byte addresses 0, 4 and 8 of the APB-style port, by the
// user only while the block is idle, which the block does not enforce; pready is always high.
// A tick runs decode with table read and step multiply, add and range
// test, apply and result load; a start runs decode with table read, apply
// and result load; a load runs decode with table write and result load.
// The single-port range table and the one multiplier set these steps. The
// next command is accepted in the same cycle the previous result is loaded.
// A result waiting under out_stall is held in the output register; the
// next command is still accepted and runs up to its result load, which
// waits until the output register frees.
// Reset (rst, synchronous) clears position, rate, segment, loop count and
// previous frame and loads the register defaults; the range table is not
// cleared and must be loaded before start.
`default_nettype none

module anim_range_playhead
  import arp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  arp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  arp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  arp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire
